/* hdl/accumulator_machine_step_top_macros.svh */
// Assertion macros for the accumulator machine top level.
// No dependencies; included by files that assert.
`ifndef ACCUMULATOR_MACHINE_STEP_TOP_MACROS_SVH
`define ACCUMULATOR_MACHINE_STEP_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define AMS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define AMS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hdl/ams_pkg.sv */
// Package for the accumulator machine: opcodes, status codes and the
// controller/datapath command and status structs. No dependencies.
package ams_pkg;
    // Width of a memory word, the accumulator and every result stored in it.
    localparam int WORD_BITS = 15;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_HALT     = 3'd1;
    localparam logic [2:0] ST_BADADDR  = 3'd2;
    localparam logic [2:0] ST_DIVZERO  = 3'd3;
    localparam logic [2:0] ST_BADOP    = 3'd4;
    localparam logic [2:0] ST_PCRANGE  = 3'd5;
    localparam logic [2:0] ST_IGNORED  = 3'd6;
    localparam logic [2:0] ST_DATAWORD = 3'd7;

    localparam logic [6:0] C_READ  = 7'h10;
    localparam logic [6:0] C_WRITE = 7'h11;
    localparam logic [6:0] C_LOAD  = 7'h20;
    localparam logic [6:0] C_STORE = 7'h21;
    localparam logic [6:0] C_ADD   = 7'h30;
    localparam logic [6:0] C_SUB   = 7'h31;
    localparam logic [6:0] C_DIV   = 7'h32;
    localparam logic [6:0] C_MUL   = 7'h33;
    localparam logic [6:0] C_MOD   = 7'h34;
    localparam logic [6:0] C_JUMP  = 7'h40;
    localparam logic [6:0] C_JNEG  = 7'h41;
    localparam logic [6:0] C_JZ    = 7'h42;
    localparam logic [6:0] C_HALT  = 7'h43;
    localparam logic [6:0] C_MOVA  = 7'h71;
    localparam logic [6:0] C_MOVR  = 7'h72;

    // Commands from controller to datapath.
    typedef struct packed {
        logic take;      // latch the input item
        logic rd_pc;     // read memory at pc
        logic rd_opnd;   // read memory at operand
        logic rd_acc;    // read memory at accumulator
        logic decode;    // latch instruction word
        logic exec;      // apply effect of instruction without divider
        logic div_go;    // start divider
        logic div_done;  // commit divider result
        logic fin;       // form result
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic is_step;   // step item on a running machine
        logic need_opnd; // instruction reads mem[operand] first
        logic need_acc;  // instruction reads mem[acc] first
        logic is_div;    // needs the divider
        logic div_busy;
    } t_stat;
endpackage

/* hdl/ams_ctrl.sv */
// Controller state machine of the accumulator machine.
// Depends on ams_pkg for command and status types.
module ams_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_res_load,
    input  logic           i_out_free,
    input  ams_pkg::t_stat i_stat,
    output ams_pkg::t_cmd  o_cmd
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_FETCH = 8'b00000010,
        S_DEC   = 8'b00000100,
        S_RDX   = 8'b00001000,
        S_EXEC  = 8'b00010000,
        S_DIV   = 8'b00100000,
        S_FIN   = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_res_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (i_stat.is_step) begin
                    o_cmd.rd_pc = 1'b1;
                    n_state = S_DEC;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DEC: begin
                o_cmd.decode = 1'b1;
                n_state = S_RDX;
            end
            S_RDX: begin
                o_cmd.rd_opnd = i_stat.need_opnd;
                o_cmd.rd_acc  = i_stat.need_acc;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_stat.is_div) begin
                    o_cmd.div_go = 1'b1;
                    n_state = S_DIV;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                if (!i_stat.div_busy) begin
                    o_cmd.div_done = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

/* hdl/ams_dp.sv */
// Datapath of the accumulator machine: memory, pc, accumulator, flags and
// a shift-subtract divider. Depends on ams_pkg.
module ams_dp #(
    parameter int MEMORY_WORDS = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ams_pkg::t_cmd        i_cmd,
    output ams_pkg::t_stat       o_stat,
    input  logic [1:0]           i_operation,
    input  logic [6:0]           i_address,
    input  logic [14:0]          i_data,
    input  logic [14:0]          i_io_value,
    output logic [2:0]           o_status,
    output logic [6:0]           o_program_counter,
    output logic [14:0]          o_accumulator_value,
    output logic                 o_write_valid,
    output logic [14:0]          o_write_data,
    output logic                 o_stopped
);
    localparam int WORD_BITS = ams_pkg::WORD_BITS;
    localparam int AW = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;
    localparam int CW = $clog2(WORD_BITS + 1);
    localparam logic [CW-1:0] DIV_STEPS = CW'(WORD_BITS);

    logic [WORD_BITS-1:0] r_mem [MEMORY_WORDS];
    logic [WORD_BITS-1:0] r_rd;
    logic [1:0]  r_op;
    logic [14:0] r_io;
    logic [6:0]  r_pc;
    logic [WORD_BITS-1:0] r_acc, r_word;
    logic r_halt, r_dfault, r_mfault, r_ofault;
    logic [2:0] r_status;
    logic r_wv;
    logic [WORD_BITS-1:0] r_wd;
    logic w_bad;
    // divider
    logic [WORD_BITS-1:0] r_q, r_rem, r_dvs;
    logic [CW-1:0] r_cnt;
    logic r_busy;

    logic [6:0] w_cmd, w_opnd;
    logic w_stopped, w_top;
    logic [WORD_BITS+1:0] w_trial;
    logic [WORD_BITS:0] w_shift;
    logic w_opnd_ok, w_acc_ok, w_needs_op;
    logic [2*WORD_BITS-1:0] w_prod;
    // Operand word: the read register holds it from the operand read onwards.
    logic [WORD_BITS-1:0] w_x;

    assign w_x    = r_rd;
    assign w_top  = r_word[WORD_BITS-1];
    assign w_cmd  = 7'((r_word >> 7) & WORD_BITS'(7'h7f));
    assign w_opnd = r_word[6:0];
    assign w_stopped = r_halt | r_dfault | r_mfault | r_ofault;
    assign w_opnd_ok = ({1'b0, w_opnd} < 8'(MEMORY_WORDS));
    assign w_acc_ok  = ({{(32-WORD_BITS){1'b0}}, r_acc} < 32'(MEMORY_WORDS));
    assign w_prod    = r_acc * w_x;

    always_comb begin
        case (w_cmd)
            ams_pkg::C_READ, ams_pkg::C_WRITE, ams_pkg::C_LOAD, ams_pkg::C_STORE,
            ams_pkg::C_ADD, ams_pkg::C_SUB, ams_pkg::C_DIV, ams_pkg::C_MUL,
            ams_pkg::C_MOD, ams_pkg::C_MOVA, ams_pkg::C_MOVR: w_needs_op = 1'b1;
            default: w_needs_op = 1'b0;
        endcase
    end

    assign o_stat.is_step   = (r_op == ams_pkg::OP_STEP) && !w_stopped
                              && ({1'b0, r_pc} < 8'(MEMORY_WORDS));
    assign o_stat.need_opnd = !w_top && w_opnd_ok && (w_cmd != ams_pkg::C_MOVR);
    assign o_stat.need_acc  = !w_top && w_acc_ok && (w_cmd == ams_pkg::C_MOVR);
    assign o_stat.is_div    = !w_top && w_opnd_ok && (w_x != '0)
                              && (w_cmd == ams_pkg::C_DIV || w_cmd == ams_pkg::C_MOD);
    assign o_stat.div_busy  = r_busy;

    // The partial remainder needs one extra bit before the trial subtraction.
    assign w_shift = {r_rem, r_q[WORD_BITS-1]};
    assign w_trial = {1'b0, w_shift} - {2'b0, r_dvs};

    // memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_operation == ams_pkg::OP_LOAD
            && {1'b0, i_address} < 8'(MEMORY_WORDS)) begin
            r_mem[AW'(i_address)] <= WORD_BITS'(i_data);
        end else if (i_cmd.exec && !w_top && !w_bad) begin
            case (w_cmd)
                ams_pkg::C_READ:  r_mem[AW'(w_opnd)] <= WORD_BITS'(r_io);
                ams_pkg::C_STORE: r_mem[AW'(w_opnd)] <= r_acc;
                ams_pkg::C_MOVA:  r_mem[AW'(r_acc)]  <= w_x;
                ams_pkg::C_MOVR:  r_mem[AW'(w_opnd)] <= w_x;
                default: ;
            endcase
        end
        if (i_cmd.rd_pc)        r_rd <= r_mem[AW'(r_pc)];
        else if (i_cmd.rd_opnd) r_rd <= r_mem[AW'(w_opnd)];
        else if (i_cmd.rd_acc)  r_rd <= r_mem[AW'(r_acc)];
    end

    always_comb begin
        w_bad = 1'b0;
        if (w_needs_op && !w_opnd_ok) w_bad = 1'b1;
        if ((w_cmd == ams_pkg::C_MOVA || w_cmd == ams_pkg::C_MOVR) && !w_acc_ok)
            w_bad = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op <= i_operation; r_io <= i_io_value;
        end
        if (i_cmd.decode) r_word <= r_rd;
    end

    // known instructions that advance pc on exec (DIV and MOD advance on commit, HALT never)
    function automatic logic w_needs_or_jump(input logic [6:0] c);
        logic k;
        k = 1'b0;
        case (c)
            ams_pkg::C_READ, ams_pkg::C_WRITE, ams_pkg::C_LOAD, ams_pkg::C_STORE,
            ams_pkg::C_ADD, ams_pkg::C_SUB, ams_pkg::C_MUL, ams_pkg::C_JUMP,
            ams_pkg::C_JNEG, ams_pkg::C_JZ, ams_pkg::C_MOVA, ams_pkg::C_MOVR: k = 1'b1;
            default: k = 1'b0;
        endcase
        return k;
    endfunction

    always_ff @(posedge i_clk) begin
        logic [7:0] w_next;
        w_next = {1'b0, r_pc} + 8'd1;
        if (!i_rst_n) begin
            r_pc <= '0; r_acc <= '0;
            r_halt <= 1'b1; r_dfault <= 1'b0; r_mfault <= 1'b0; r_ofault <= 1'b0;
            r_status <= ams_pkg::ST_IGNORED; r_wv <= 1'b0; r_wd <= '0;
            r_busy <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_cmd.take) begin
                r_wv <= 1'b0; r_wd <= '0;
                r_status <= ams_pkg::ST_IGNORED;
                if (i_operation == ams_pkg::OP_LOAD) begin
                    r_status <= ({1'b0, i_address} < 8'(MEMORY_WORDS))
                                ? ams_pkg::ST_OK : ams_pkg::ST_BADADDR;
                end else if (i_operation == ams_pkg::OP_START) begin
                    if ({1'b0, i_address} < 8'(MEMORY_WORDS)) begin
                        r_pc <= i_address;
                        r_halt <= 1'b0; r_dfault <= 1'b0;
                        r_mfault <= 1'b0; r_ofault <= 1'b0;
                        r_status <= ams_pkg::ST_OK;
                    end else begin
                        r_status <= ams_pkg::ST_PCRANGE;
                    end
                end else if (i_operation == ams_pkg::OP_STEP) begin
                    if (!w_stopped && !({1'b0, r_pc} < 8'(MEMORY_WORDS))) begin
                        r_mfault <= 1'b1;
                        r_status <= ams_pkg::ST_PCRANGE;
                    end
                end
            end
            if (i_cmd.exec) begin
                w_next = {1'b0, r_pc} + 8'd1;
                if (w_top) begin
                    r_halt <= 1'b1; r_status <= ams_pkg::ST_DATAWORD;
                end else if (w_bad) begin
                    r_halt <= 1'b1; r_status <= ams_pkg::ST_BADADDR;
                end else begin
                    r_status <= ams_pkg::ST_OK;
                    case (w_cmd)
                        ams_pkg::C_READ, ams_pkg::C_STORE,
                        ams_pkg::C_MOVA, ams_pkg::C_MOVR: ;
                        ams_pkg::C_WRITE: begin r_wv <= 1'b1; r_wd <= w_x; end
                        ams_pkg::C_LOAD:  r_acc <= w_x;
                        ams_pkg::C_ADD:   r_acc <= r_acc + w_x;
                        ams_pkg::C_SUB:   r_acc <= r_acc - w_x;
                        ams_pkg::C_MUL:   r_acc <= w_prod[WORD_BITS-1:0];
                        ams_pkg::C_DIV, ams_pkg::C_MOD: begin
                            r_dfault <= 1'b1; r_status <= ams_pkg::ST_DIVZERO;
                        end
                        ams_pkg::C_JUMP:  w_next = {1'b0, w_opnd};
                        ams_pkg::C_JNEG:  if (r_acc[WORD_BITS-1]) w_next = {1'b0, w_opnd};
                        ams_pkg::C_JZ:    if (r_acc == '0) w_next = {1'b0, w_opnd};
                        ams_pkg::C_HALT: begin
                            r_halt <= 1'b1; r_status <= ams_pkg::ST_HALT;
                        end
                        default: begin
                            r_ofault <= 1'b1; r_status <= ams_pkg::ST_BADOP;
                        end
                    endcase
                    if (w_cmd != ams_pkg::C_HALT && w_cmd != ams_pkg::C_DIV
                        && w_cmd != ams_pkg::C_MOD && w_needs_or_jump(w_cmd)) begin
                        if (w_next < 8'(MEMORY_WORDS)) r_pc <= w_next[6:0];
                        else begin
                            r_mfault <= 1'b1; r_status <= ams_pkg::ST_PCRANGE;
                        end
                    end
                end
            end
            if (i_cmd.div_go) begin
                r_q <= r_acc; r_rem <= '0; r_dvs <= w_x;
                r_cnt <= DIV_STEPS; r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q <= {r_q[WORD_BITS-2:0], !w_trial[WORD_BITS+1]};
                r_rem <= w_trial[WORD_BITS+1] ? w_shift[WORD_BITS-1:0]
                                              : w_trial[WORD_BITS-1:0];
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) r_busy <= 1'b0;
            end
            if (i_cmd.div_done) begin
                r_acc <= (w_cmd == ams_pkg::C_DIV) ? r_q : r_rem;
                r_status <= ams_pkg::ST_OK;
                w_next = {1'b0, r_pc} + 8'd1;
                if (w_next < 8'(MEMORY_WORDS)) r_pc <= w_next[6:0];
                else begin
                    r_mfault <= 1'b1; r_status <= ams_pkg::ST_PCRANGE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            o_status <= r_status;
            o_program_counter <= r_pc;
            o_accumulator_value <= 15'(r_acc);
            o_write_valid <= r_wv;
            o_write_data <= 15'(r_wd);
            o_stopped <= w_stopped;
        end
    end
endmodule

/* hdl/accumulator_machine_step_top.sv */
// Top level of the accumulator machine step block.
// Depends on ams_pkg, ams_ctrl, ams_dp and the assertion macro header.
//
// Usage: one input transfer on the s_axis group carries an item: a memory
// load, a start at an address (clears all flags) or one instruction step.
// Every item yields exactly one result transfer on the m_axis group with
// the status, program counter, accumulator, write word and stopped flag.
// Loads, starts and stopped steps pass from acceptance through the fetch
// and finish states to the result register; an ordinary instruction adds
// decode, operand read and execute, as fetch, decode and operand read share
// the single memory read port. DIVIDE and MOD by a nonzero divisor add the
// shift-subtract divider and its commit. The input is ready again in the
// cycle after the result is loaded. One item is in flight at a time; the
// result register is separate from the datapath so a finished result waits
// there while the next item is accepted. After reset the machine is halted
// with pc and accumulator zero; memory holds nothing defined until loaded.
// When the receiver stalls the result is held and the controller waits
// before overwriting it.
`include "accumulator_machine_step_top_macros.svh"
module accumulator_machine_step_top #(
    parameter int MEMORY_WORDS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[1:0], address[8:2], data[23:9], io_value[38:24], zero pad
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], program_counter[9:3], accumulator_value[24:10],
    // write_valid[25], write_data[40:26], stopped[41], zero pad
    output logic [47:0] m_axis_tdata
);
    ams_pkg::t_cmd  w_cmd;
    ams_pkg::t_stat w_stat;
    logic w_res_load, w_out_free;
    logic [2:0] w_status;
    logic [6:0] w_pc;
    logic [14:0] w_acc, w_wd;
    logic w_wv, w_stop;
    logic r_out_valid;
    logic [47:0] r_out;

    assign w_out_free = !r_out_valid || m_axis_tready;

    ams_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_res_load(w_res_load), .i_out_free(w_out_free),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    ams_dp #(.MEMORY_WORDS(MEMORY_WORDS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_operation(s_axis_tdata[1:0]), .i_address(s_axis_tdata[8:2]),
        .i_data(s_axis_tdata[23:9]), .i_io_value(s_axis_tdata[38:24]),
        .o_status(w_status), .o_program_counter(w_pc),
        .o_accumulator_value(w_acc), .o_write_valid(w_wv),
        .o_write_data(w_wd), .o_stopped(w_stop)
    );

    // Output register: loaded once per item, held while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_out <= {6'd0, w_stop, w_wd, w_wv, w_acc, w_pc, w_status};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // A result is only loaded when the output register is free.
    `AMS_ASSERT_IMP(a_no_overwrite, w_res_load, !r_out_valid || m_axis_tready)
    // Input is only taken while the controller is idle.
    `AMS_ASSERT_NXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // The write word is zero whenever no write was emitted.
    `AMS_ASSERT_IMP(a_wdata_zero, m_axis_tvalid && !m_axis_tdata[25],
                    m_axis_tdata[40:26] == 15'd0)
endmodule

/* sim/testbench.sv */
// Self-checking testbench for the accumulator machine step block.
// Depends on ams_pkg and accumulator_machine_step_top from the hdl folder.
`timescale 1ns / 100ps
module testbench;
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // operation[1:0], address[8:2], data[23:9], io_value[38:24], zero pad
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // status[2:0], program_counter[9:3], accumulator_value[24:10],
    // write_valid[25], write_data[40:26], stopped[41], zero pad
    logic [47:0] m_axis_tdata;

    typedef struct packed {
        logic [14:0] io_value;
        logic [14:0] data;
        logic [6:0]  address;
        logic [1:0]  operation;
    } t_item;

    typedef struct packed {
        logic        stopped;
        logic [14:0] write_data;
        logic        write_valid;
        logic [14:0] acc_value;
        logic [6:0]  pc_value;
        logic [2:0]  status;
    } t_outcome;

    accumulator_machine_step_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predictor state: a private copy of the machine.
    logic [14:0] mirror_mem [128];
    logic [6:0]  mirror_pc;
    logic [14:0] mirror_acc;
    logic        halt_f, div_f, mem_f, op_f;
    // Tracks which words were written so stimulus never reads undefined memory.
    bit          written [128];

    t_item    pending_items[$];
    t_outcome expected_outcomes[$];
    int       failures = 0;
    int       cycle_count = 0;
    int       hold_off = 0;

    initial i_clk = 0;
    always #6 i_clk = ~i_clk;

    // Work out the result of one accepted item and advance the mirror.
    function automatic t_outcome predict_machine(t_item it);
        t_outcome    r;
        logic [14:0] w, v;
        logic [6:0]  cmd, opnd;
        logic [7:0]  nxt;
        bit          done;
        r = '0;
        done = 0;
        if (it.operation == ams_pkg::OP_LOAD) begin
            mirror_mem[it.address] = it.data;
            r.status = ams_pkg::ST_OK;
        end else if (it.operation == ams_pkg::OP_START) begin
            mirror_pc = it.address;
            {halt_f, div_f, mem_f, op_f} = '0;
            r.status = ams_pkg::ST_OK;
        end else if (it.operation != ams_pkg::OP_STEP || halt_f || div_f || mem_f || op_f)
        begin
            r.status = ams_pkg::ST_IGNORED;
        end else begin
            w = mirror_mem[mirror_pc];
            cmd = w[13:7];
            opnd = w[6:0];
            nxt = {1'b0, mirror_pc} + 8'd1;
            r.status = ams_pkg::ST_OK;
            if (w[14]) begin
                halt_f = 1;
                r.status = ams_pkg::ST_DATAWORD;
                done = 1;
            end else begin
                // All 7-bit operands are in range with 128 words.
                case (cmd)
                    ams_pkg::C_READ:  mirror_mem[opnd] = it.io_value;
                    ams_pkg::C_WRITE: begin
                        r.write_valid = 1;
                        r.write_data = mirror_mem[opnd];
                    end
                    ams_pkg::C_LOAD:  mirror_acc = mirror_mem[opnd];
                    ams_pkg::C_STORE: mirror_mem[opnd] = mirror_acc;
                    ams_pkg::C_ADD:   mirror_acc = mirror_acc + mirror_mem[opnd];
                    ams_pkg::C_SUB:   mirror_acc = mirror_acc - mirror_mem[opnd];
                    ams_pkg::C_MUL:   mirror_acc = mirror_acc * mirror_mem[opnd];
                    ams_pkg::C_DIV, ams_pkg::C_MOD: begin
                        v = mirror_mem[opnd];
                        if (v == 0) begin
                            div_f = 1;
                            r.status = ams_pkg::ST_DIVZERO;
                            done = 1;
                        end else
                            mirror_acc = (cmd == ams_pkg::C_DIV) ? mirror_acc / v
                                                                 : mirror_acc % v;
                    end
                    ams_pkg::C_JUMP:  nxt = {1'b0, opnd};
                    ams_pkg::C_JNEG:  if (mirror_acc[14]) nxt = {1'b0, opnd};
                    ams_pkg::C_JZ:    if (mirror_acc == 0) nxt = {1'b0, opnd};
                    ams_pkg::C_HALT: begin
                        halt_f = 1;
                        r.status = ams_pkg::ST_HALT;
                        done = 1;
                    end
                    ams_pkg::C_MOVA, ams_pkg::C_MOVR: begin
                        if (mirror_acc >= 15'd128) begin
                            halt_f = 1;
                            r.status = ams_pkg::ST_BADADDR;
                            done = 1;
                        end else if (cmd == ams_pkg::C_MOVA)
                            mirror_mem[mirror_acc[6:0]] = mirror_mem[opnd];
                        else
                            mirror_mem[opnd] = mirror_mem[mirror_acc[6:0]];
                    end
                    default: begin
                        op_f = 1;
                        r.status = ams_pkg::ST_BADOP;
                        done = 1;
                    end
                endcase
                if (!done) begin
                    if (nxt[7]) begin
                        mem_f = 1;
                        r.status = ams_pkg::ST_PCRANGE;
                    end else
                        mirror_pc = nxt[6:0];
                end
            end
        end
        r.pc_value = mirror_pc;
        r.acc_value = mirror_acc;
        r.stopped = halt_f | div_f | mem_f | op_f;
        return r;
    endfunction

    // Stimulus-side tracker: decides whether a step would read unwritten
    // memory. It runs the same prediction on a scratch copy.
    logic [14:0] plan_mem [128];
    logic [6:0]  plan_pc;
    logic [14:0] plan_acc;
    logic        plan_stop;

    function automatic bit step_is_safe();
        logic [14:0] w;
        logic [6:0]  cmd, opnd;
        if (plan_stop) return 1;
        if (!written[plan_pc]) return 0;
        w = plan_mem[plan_pc];
        if (w[14]) return 1;
        cmd = w[13:7];
        opnd = w[6:0];
        case (cmd)
            ams_pkg::C_WRITE, ams_pkg::C_LOAD, ams_pkg::C_ADD, ams_pkg::C_SUB,
            ams_pkg::C_MUL, ams_pkg::C_DIV, ams_pkg::C_MOD:
                return written[opnd];
            ams_pkg::C_MOVA: return plan_acc >= 128 || written[opnd];
            ams_pkg::C_MOVR: return plan_acc >= 128 || written[plan_acc[6:0]];
            default: return 1;
        endcase
    endfunction

    // Queue an item and keep the planning copy in step with it.
    task automatic queue_item(t_item it);
        logic [14:0] w;
        logic [6:0]  cmd, opnd;
        if (it.operation == ams_pkg::OP_STEP && !plan_stop) begin
            w = plan_mem[plan_pc];
            cmd = w[13:7];
            opnd = w[6:0];
            if (!w[14]) begin
                if (cmd == ams_pkg::C_READ || cmd == ams_pkg::C_STORE) written[opnd] = 1;
                else if (cmd == ams_pkg::C_MOVA && plan_acc < 128)
                    written[plan_acc[6:0]] = 1;
                else if (cmd == ams_pkg::C_MOVR && plan_acc < 128) written[opnd] = 1;
            end
        end else if (it.operation == ams_pkg::OP_LOAD)
            written[it.address] = 1;
        // Reuse the predictor on the planning copy by swapping state in.
        begin
            logic [14:0] sm [128];
            logic [6:0]  spc;
            logic [14:0] sacc;
            logic        sh, sd, smf, so;
            t_outcome    dummy;
            sm = mirror_mem; spc = mirror_pc; sacc = mirror_acc;
            {sh, sd, smf, so} = {halt_f, div_f, mem_f, op_f};
            mirror_mem = plan_mem; mirror_pc = plan_pc; mirror_acc = plan_acc;
            {halt_f, div_f, mem_f, op_f} = {plan_stop, 3'b0};
            dummy = predict_machine(it);
            plan_mem = mirror_mem; plan_pc = mirror_pc; plan_acc = mirror_acc;
            plan_stop = dummy.stopped;
            mirror_mem = sm; mirror_pc = spc; mirror_acc = sacc;
            {halt_f, div_f, mem_f, op_f} = {sh, sd, smf, so};
        end
        pending_items.push_back(it);
    endtask

    function automatic t_item make_item(logic [1:0] op, logic [6:0] a, logic [14:0] d);
        t_item it;
        it.operation = op;
        it.address = a;
        it.data = d;
        it.io_value = 15'($urandom_range(0, 32767));
        return it;
    endfunction

    function automatic logic [14:0] instr(logic [6:0] cmd, logic [6:0] opnd);
        return {1'b0, cmd, opnd};
    endfunction

    // Step while safe; when not, start somewhere safe instead.
    task automatic queue_step();
        if (step_is_safe())
            queue_item(make_item(ams_pkg::OP_STEP, 7'($urandom), 15'($urandom)));
        else
            queue_item(make_item(ams_pkg::OP_START, 7'd0, 15'($urandom)));
    endtask

    logic [6:0] op_pool [15];

    task automatic build_stimulus();
        int          n, k, base;
        logic [6:0]  cmd;
        logic [14:0] w;
        t_item       it;
        plan_pc = 0; plan_acc = 0; plan_stop = 1;
        for (int i = 0; i < 128; i++) begin
            plan_mem[i] = 0;
            written[i] = 0;
        end
        op_pool = '{ams_pkg::C_READ, ams_pkg::C_WRITE, ams_pkg::C_LOAD, ams_pkg::C_STORE,
                    ams_pkg::C_ADD, ams_pkg::C_SUB, ams_pkg::C_DIV, ams_pkg::C_MUL,
                    ams_pkg::C_MOD, ams_pkg::C_JUMP, ams_pkg::C_JNEG, ams_pkg::C_JZ,
                    ams_pkg::C_HALT, ams_pkg::C_MOVA, ams_pkg::C_MOVR};
        // Directed: step while halted, unused operation, extremes, data word,
        // unknown opcode, division by zero, pc running off the end.
        queue_item(make_item(ams_pkg::OP_STEP, 7'd0, 15'd0));
        it = make_item(2'd3, 7'h7f, 15'h7fff); it.io_value = 15'h7fff;
        queue_item(it);
        queue_item(make_item(ams_pkg::OP_LOAD, 7'd100, 15'h7fff));
        queue_item(make_item(ams_pkg::OP_LOAD, 7'd101, 15'd0));
        queue_item(make_item(ams_pkg::OP_LOAD, 7'd0, instr(ams_pkg::C_LOAD, 7'd100)));
        queue_item(make_item(ams_pkg::OP_LOAD, 7'd1, instr(ams_pkg::C_ADD, 7'd100)));
        queue_item(make_item(ams_pkg::OP_LOAD, 7'd2, instr(ams_pkg::C_WRITE, 7'd100)));
        queue_item(make_item(ams_pkg::OP_LOAD, 7'd3, instr(ams_pkg::C_DIV, 7'd101)));
        queue_item(make_item(ams_pkg::OP_LOAD, 7'd4, instr(7'h7f, 7'd0)));
        queue_item(make_item(ams_pkg::OP_LOAD, 7'd5, 15'h4000));
        queue_item(make_item(ams_pkg::OP_LOAD, 7'd127, instr(ams_pkg::C_MUL, 7'd100)));
        queue_item(make_item(ams_pkg::OP_START, 7'd0, 15'd0));
        for (int i = 0; i < 4; i++) queue_step();
        queue_item(make_item(ams_pkg::OP_START, 7'd4, 15'd0));
        queue_step();
        queue_item(make_item(ams_pkg::OP_START, 7'd5, 15'd0));
        queue_step();
        queue_item(make_item(ams_pkg::OP_START, 7'd127, 15'd0));
        queue_step();
        queue_step();
        // Random part: mostly short well-formed programs with random content.
        n = pending_items.size();
        while (n < 760) begin
            base = $urandom_range(0, 120);
            k = $urandom_range(3, 10);
            // Data words in a pool of addresses used as operands.
            for (int j = 0; j < 4; j++)
                queue_item(make_item(ams_pkg::OP_LOAD, 7'($urandom_range(100, 127)),
                                     ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 3))
                                                                 : 15'($urandom)));
            for (int j = 0; j < k; j++) begin
                cmd = op_pool[$urandom_range(0, 14)];
                w = ($urandom_range(0, 30) == 0) ? 15'($urandom) : instr(cmd,
                    (cmd == ams_pkg::C_JUMP || cmd == ams_pkg::C_JNEG || cmd == ams_pkg::C_JZ)
                        ? 7'($urandom_range(base, 127)) : 7'($urandom_range(100, 127)));
                if ($urandom_range(0, 40) == 0) w = instr(7'($urandom), 7'($urandom));
                queue_item(make_item(ams_pkg::OP_LOAD, 7'(base + j), w));
            end
            if ($urandom_range(0, 10) == 0)
                queue_item(make_item(2'd3, 7'($urandom), 15'($urandom)));
            queue_item(make_item(ams_pkg::OP_START, 7'(base), 15'd0));
            for (int j = 0; j < k + 2; j++) queue_step();
            n = pending_items.size();
        end
    endtask

    // Driver: offers pending items with random gaps.
    int gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 0;
            s_axis_tdata <= '0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
            // Holding the offer until it is accepted.
        end else if (gap > 0) begin
            s_axis_tvalid <= 0;
            gap <= gap - 1;
        end else if (pending_items.size() > 0) begin
            s_axis_tvalid <= 1;
            s_axis_tdata <= {1'b0, pending_items.pop_front()};
            gap <= ($urandom_range(0, 3) != 0) ? 0 :
                   ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
        end else
            s_axis_tvalid <= 0;
    end

    // Each accepted transfer is predicted at the edge where it happens.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            expected_outcomes.push_back(predict_machine(t_item'(s_axis_tdata[38:0])));
    end

    // Receiver back-pressure, with one long hold-off early in the run.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 0;
        else if (hold_off > 0) begin
            m_axis_tready <= 0;
            hold_off <= hold_off - 1;
        end else if (cycle_count == 600)
            hold_off <= 400;
        else if ($urandom_range(0, 3) == 0)
            m_axis_tready <= ($urandom_range(0, 20) == 0) ? 0 : ~m_axis_tready;
        else
            m_axis_tready <= 1;
    end

    // Monitor: compares each result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_outcome got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_outcome'(m_axis_tdata[41:0]);
            if (expected_outcomes.size() == 0) begin
                failures++;
                $display("%0t: unexpected result %h", $time, got);
            end else begin
                want = expected_outcomes.pop_front();
                if (got.status != want.status || got.pc_value != want.pc_value ||
                    got.acc_value != want.acc_value || got.write_valid != want.write_valid ||
                    got.write_data != want.write_data || got.stopped != want.stopped) begin
                    failures++;
                    $display("%0t: expected st=%0d pc=%0d acc=%h wv=%0d wd=%h stop=%0d",
                             $time, want.status, want.pc_value, want.acc_value,
                             want.write_valid, want.write_data, want.stopped);
                    $display("%0t: actual   st=%0d pc=%0d acc=%h wv=%0d wd=%h stop=%0d",
                             $time, got.status, got.pc_value, got.acc_value,
                             got.write_valid, got.write_data, got.stopped);
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000) begin
            $display("accumulator_machine_step_top test failed");
            $finish;
        end
    end

    initial begin
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 0;
        mirror_pc = 0;
        mirror_acc = 0;
        {halt_f, div_f, mem_f, op_f} = 4'b1000;
        for (int i = 0; i < 128; i++) mirror_mem[i] = 0;
        build_stimulus();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        wait (pending_items.size() == 0);
        @(posedge i_clk);
        while (s_axis_tvalid) @(posedge i_clk);
        while (expected_outcomes.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (failures == 0 && expected_outcomes.size() == 0)
            $display("accumulator_machine_step_top test passed");
        else
            $display("accumulator_machine_step_top test failed");
        $finish;
    end
endmodule

/* files.f */
+incdir+hdl
hdl/ams_pkg.sv
hdl/ams_ctrl.sv
hdl/ams_dp.sv
hdl/accumulator_machine_step_top.sv
sim/testbench.sv
